// File: hw/rtl/ngtl_pkg.sv
// Shared types and constants for the nearest grid table lookup block.
`timescale 1ns / 1ps

package ngtl_pkg;

   // Operation codes carried by an input item.
   localparam logic [1:0] OP_LOAD_ROW  = 2'd0;
   localparam logic [1:0] OP_LOAD_COL  = 2'd1;
   localparam logic [1:0] OP_LOAD_GRID = 2'd2;
   localparam logic [1:0] OP_QUERY     = 2'd3;

   // Field widths of the item interfaces.
   localparam int OP_W    = 2;
   localparam int FIELD_W = 5;
   localparam int KEY_W   = 32;
   localparam int DIST_W  = KEY_W + 1;

   // Breakpoint counts and scan counters hold up to 63.
   localparam int IDX_W = 6;

   // Register file geometry and register indexes.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_ROWS_IN_USE = 1'b0;
   localparam logic CSR_COLS_IN_USE = 1'b1;

   // Axis selection for a scan.
   localparam logic AXIS_ROW = 1'b0;
   localparam logic AXIS_COL = 1'b1;

   // Raw count registers as written by software.
   typedef struct packed {
      logic [IDX_W-1:0] rows_raw;
      logic [IDX_W-1:0] cols_raw;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic scan_start;
      logic axis;
      logic scan_eval;
      logic resolve;
      logic grid_read;
      logic out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic stop;
      logic out_free;
   } dp_stat_type;

endpackage

// File: hw/rtl/ngtl_csr.sv
// Configuration register file holding the row and column breakpoint counts.
`timescale 1ns / 1ps

module ngtl_csr import ngtl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [IDX_W-1:0] rows_ff, rows_in;
   logic [IDX_W-1:0] cols_ff, cols_in;
   logic             wr_en;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   // Next values of the count registers.
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr_en) begin
         unique case (reg_sel)
            CSR_ROWS_IN_USE: rows_in = csr_pwdata[IDX_W-1:0];
            CSR_COLS_IN_USE: cols_in = csr_pwdata[IDX_W-1:0];
            default:         rows_in = rows_ff;
         endcase
      end
   end

   // Both counts come out of reset at one.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= IDX_W'(1);
         cols_ff <= IDX_W'(1);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // Read back the selected register.
   always_comb begin
      unique case (reg_sel)
         CSR_ROWS_IN_USE: csr_prdata = CSR_DATA_W'(rows_ff);
         CSR_COLS_IN_USE: csr_prdata = CSR_DATA_W'(cols_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.rows_raw = rows_ff;
   assign cfg.cols_raw = cols_ff;

endmodule

// File: hw/rtl/ngtl_ctrl.sv
// Controller state machine that sequences the row scan, column scan and grid read.
`timescale 1ns / 1ps

module ngtl_ctrl import ngtl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_accept,
   input  logic [OP_W-1:0] req_op,
   input  dp_stat_type     stat,
   output logic            req_stall,
   output dp_cmd_type      cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_ROW_START = 4'd1;
   localparam logic [3:0] S_ROW_SCAN  = 4'd2;
   localparam logic [3:0] S_ROW_RES   = 4'd3;
   localparam logic [3:0] S_COL_START = 4'd4;
   localparam logic [3:0] S_COL_SCAN  = 4'd5;
   localparam logic [3:0] S_COL_RES   = 4'd6;
   localparam logic [3:0] S_GRID      = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;

   logic [3:0] state_ff, state_in;

   // Loads pass straight through; only a query leaves the idle state.
   assign req_stall = (state_ff != S_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_op == OP_QUERY)) begin
               state_in = S_ROW_START;
            end
         end
         S_ROW_START: begin
            cmd.scan_start = 1'b1;
            cmd.axis       = AXIS_ROW;
            state_in       = S_ROW_SCAN;
         end
         S_ROW_SCAN: begin
            cmd.scan_eval = 1'b1;
            if (stat.stop) begin
               state_in = S_ROW_RES;
            end
         end
         S_ROW_RES: begin
            cmd.resolve = 1'b1;
            state_in    = S_COL_START;
         end
         S_COL_START: begin
            cmd.scan_start = 1'b1;
            cmd.axis       = AXIS_COL;
            state_in       = S_COL_SCAN;
         end
         S_COL_SCAN: begin
            cmd.scan_eval = 1'b1;
            if (stat.stop) begin
               state_in = S_COL_RES;
            end
         end
         S_COL_RES: begin
            cmd.resolve = 1'b1;
            state_in    = S_GRID;
         end
         S_GRID: begin
            cmd.grid_read = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // Wait here until the output register can take the result.
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted query always starts with the row scan.
   a_query_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_op == OP_QUERY) |=> state_ff == S_ROW_START)
      else $error("query accepted but row scan did not start");

   // A result is only presented when the output register is free.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free && (state_ff == S_DONE))
      else $error("result loaded while output register busy");

endmodule

// File: hw/rtl/ngtl_dp.sv
// Datapath with the axis and grid memories, the shared scan compare and the output register.
`timescale 1ns / 1ps

module ngtl_dp import ngtl_pkg::*; #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  dp_cmd_type               cmd,
   output dp_stat_type              stat,
   input  logic                     req_accept,
   input  logic [OP_W-1:0]          req_op,
   input  logic [FIELD_W-1:0]       req_row_index,
   input  logic [FIELD_W-1:0]       req_col_index,
   input  logic signed [KEY_W-1:0]  req_load_data,
   input  logic signed [KEY_W-1:0]  req_row_query,
   input  logic signed [KEY_W-1:0]  req_col_query,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [KEY_W-1:0]  rsp_table_value,
   output logic [FIELD_W-1:0]       rsp_row_chosen,
   output logic [FIELD_W-1:0]       rsp_col_chosen
);

   localparam int ROW_AW  = $clog2(MAX_ROWS);
   localparam int COL_AW  = $clog2(MAX_COLS);
   localparam int GRID_D  = MAX_ROWS * MAX_COLS;
   localparam int GRID_AW = $clog2(GRID_D);

   // Clamp a raw count to the range one to the store depth.
   function automatic logic [IDX_W-1:0] clamp_count(input logic [IDX_W-1:0] raw,
                                                    input int maxv);
      logic [IDX_W-1:0] n;
      if (raw == '0) begin
         n = IDX_W'(1);
      end else if (int'(raw) > maxv) begin
         n = IDX_W'(maxv);
      end else begin
         n = raw;
      end
      return n;
   endfunction

   logic [KEY_W-1:0]   row_mem_ff  [MAX_ROWS];
   logic [KEY_W-1:0]   col_mem_ff  [MAX_COLS];
   logic [KEY_W-1:0]   grid_mem_ff [GRID_D];
   logic [KEY_W-1:0]   row_rd_ff;
   logic [KEY_W-1:0]   col_rd_ff;
   logic [KEY_W-1:0]   grid_rd_ff;
   logic [KEY_W-1:0]   row_key_ff;
   logic [KEY_W-1:0]   col_key_ff;
   logic               axis_ff;
   logic [IDX_W-1:0]   iss_ff;
   logic [IDX_W-1:0]   eidx_ff;
   logic [DIST_W-1:0]  cur_dist_ff;
   logic [DIST_W-1:0]  prev_dist_ff;
   logic [IDX_W-1:0]   row_sel_ff;
   logic [IDX_W-1:0]   col_sel_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]   rsp_value_ff;
   logic [FIELD_W-1:0] rsp_row_ff;
   logic [FIELD_W-1:0] rsp_col_ff;

   logic [IDX_W-1:0]   n_rows;
   logic [IDX_W-1:0]   n_cols;
   logic [IDX_W-1:0]   count_sel;
   logic [IDX_W-1:0]   raddr;
   logic [KEY_W-1:0]   key;
   logic [KEY_W-1:0]   axis_data;
   logic [DIST_W-1:0]  diff;
   logic [DIST_W-1:0]  abs_gap;
   logic               hit;
   logic               last;
   logic [IDX_W-1:0]   pick;
   logic               row_we;
   logic               col_we;
   logic               grid_we;
   logic [GRID_AW-1:0] grid_waddr;
   logic [GRID_AW-1:0] grid_raddr;

   assign n_rows = clamp_count(cfg.rows_raw, MAX_ROWS);
   assign n_cols = clamp_count(cfg.cols_raw, MAX_COLS);

   // Load items write the stores; out-of-range positions are dropped.
   assign row_we  = req_accept && (req_op == OP_LOAD_ROW) && (int'(req_row_index) < MAX_ROWS);
   assign col_we  = req_accept && (req_op == OP_LOAD_COL) && (int'(req_col_index) < MAX_COLS);
   assign grid_we = req_accept && (req_op == OP_LOAD_GRID)
                    && (int'(req_row_index) < MAX_ROWS) && (int'(req_col_index) < MAX_COLS);

   assign grid_waddr = GRID_AW'(req_row_index) * GRID_AW'(MAX_COLS) + GRID_AW'(req_col_index);
   assign grid_raddr = GRID_AW'(row_sel_ff) * GRID_AW'(MAX_COLS) + GRID_AW'(col_sel_ff);

   // The scan reads breakpoint zero on its first cycle, then one ahead of the compare.
   assign raddr = cmd.scan_start ? '0 : iss_ff;

   // Axis memories with registered reads.
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem_ff[ROW_AW'(req_row_index)] <= req_load_data;
      end
      row_rd_ff <= row_mem_ff[ROW_AW'(raddr)];
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem_ff[COL_AW'(req_col_index)] <= req_load_data;
      end
      col_rd_ff <= col_mem_ff[COL_AW'(raddr)];
   end

   // Grid memory, read once per query.
   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem_ff[grid_waddr] <= req_load_data;
      end
      if (cmd.grid_read) begin
         grid_rd_ff <= grid_mem_ff[grid_raddr];
      end
   end

   // Capture the keys of an accepted query.
   always_ff @(posedge clock) begin
      if (req_accept && (req_op == OP_QUERY)) begin
         row_key_ff <= req_row_query;
         col_key_ff <= req_col_query;
      end
   end

   // One subtract gives both the at-least test and the distance.
   assign key       = (axis_ff == AXIS_COL) ? col_key_ff : row_key_ff;
   assign axis_data = (axis_ff == AXIS_COL) ? col_rd_ff : row_rd_ff;
   assign count_sel = (axis_ff == AXIS_COL) ? n_cols : n_rows;
   assign diff      = {axis_data[KEY_W-1], axis_data} - {key[KEY_W-1], key};
   assign hit       = ~diff[DIST_W-1];
   assign abs_gap   = diff[DIST_W-1] ? (~diff + DIST_W'(1)) : diff;
   assign last      = (eidx_ff == (count_sel - IDX_W'(1)));

   assign stat.stop     = hit || last;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   // Step back when the lower neighbour is strictly closer; ties keep the upper index.
   assign pick = ((eidx_ff != '0) && (prev_dist_ff < cur_dist_ff))
                 ? (eidx_ff - IDX_W'(1)) : eidx_ff;

   // Scan counters, distance history and chosen indexes.
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         axis_ff <= cmd.axis;
         iss_ff  <= IDX_W'(1);
         eidx_ff <= '0;
      end else if (cmd.scan_eval) begin
         prev_dist_ff <= cur_dist_ff;
         cur_dist_ff  <= abs_gap;
         if (!stat.stop) begin
            iss_ff  <= iss_ff + IDX_W'(1);
            eidx_ff <= iss_ff;
         end
      end
      if (cmd.resolve) begin
         if (axis_ff == AXIS_COL) begin
            col_sel_ff <= pick;
         end else begin
            row_sel_ff <= pick;
         end
      end
   end

   // Output register: takes a result while the previous one leaves.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_value_ff <= grid_rd_ff;
         rsp_row_ff   <= FIELD_W'(row_sel_ff);
         rsp_col_ff   <= FIELD_W'(col_sel_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_table_value = rsp_value_ff;
   assign rsp_row_chosen  = rsp_row_ff;
   assign rsp_col_chosen  = rsp_col_ff;

   // The compare never runs past the last breakpoint in use.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_eval |-> eidx_ff < count_sel)
      else $error("scan index beyond breakpoint count");

   // A chosen row index always lies inside the rows in use.
   a_row_sel_range: assert property (@(posedge clock) disable iff (reset)
      cmd.resolve && (axis_ff == AXIS_ROW) |=> row_sel_ff < n_rows)
      else $error("chosen row index out of range");

   // A result only appears after the controller loads one.
   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("result valid without a load");

endmodule

// File: hw/rtl/nearest_grid_table_lookup.sv
// Top level of the nearest-breakpoint two-axis table lookup.
`timescale 1ns / 1ps

// Usage:
// Request items carry an op code. Row breakpoint, column breakpoint and grid
// loads are taken one per cycle while no query is in progress and write the
// stores; they produce no result. A query item carries a row key and a column
// key in signed Q16.16 and yields one result item with the grid value and the
// two chosen indices. Breakpoint counts are set through the csr_ port; the
// user must write them only while idle, as the block itself does not enforce
// it. A query scans the row axis, then the column axis, one breakpoint per
// cycle through a single compare unit, then reads the grid. Each axis scan
// stops at the first breakpoint at least the key, or at the last in use. The
// controller steps through start, scan and resolve states per axis, then a
// grid read, then a done state that loads the output register before the
// next item is taken. req_stall is high while a query is in progress.
// Reset clears the controller and the output valid and sets both counts to
// one; the stores hold nothing defined until loaded.
// When the receiver stalls, the result holds in the output register and a
// following query waits in its last step until that register frees.

module nearest_grid_table_lookup import ngtl_pkg::*; #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_op,
   input  logic [FIELD_W-1:0]      req_row_index,
   input  logic [FIELD_W-1:0]      req_col_index,
   input  logic signed [KEY_W-1:0] req_load_data,
   input  logic signed [KEY_W-1:0] req_row_query,
   input  logic signed [KEY_W-1:0] req_col_query,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [KEY_W-1:0] rsp_table_value,
   output logic [FIELD_W-1:0]      rsp_row_chosen,
   output logic [FIELD_W-1:0]      rsp_col_chosen,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   cfg_type     cfg;
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_accept;

   assign req_accept = req_valid && !req_stall;

   ngtl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ngtl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_op     (req_op),
      .stat       (stat),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   ngtl_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .stat            (stat),
      .req_accept      (req_accept),
      .req_op          (req_op),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_load_data   (req_load_data),
      .req_row_query   (req_row_query),
      .req_col_query   (req_col_query),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_table_value (rsp_table_value),
      .rsp_row_chosen  (rsp_row_chosen),
      .rsp_col_chosen  (rsp_col_chosen)
   );

endmodule
